>>> rtl/lsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_pkg
// shared types and constants of the line sensor position block
// ----------------------------------------------------------------------------
package lsp_pkg;

   // sizes of the fields and of the state
   localparam int SAMPLE_BITS     = 10;
   localparam int CHANNEL_BITS    = 4;
   localparam int KIND_BITS       = 2;
   localparam int NUM_BITS        = 5;
   localparam int LEVEL_BITS      = 10;
   localparam int POS_BITS        = 14;
   localparam int COUNT_BITS      = 5;
   localparam int WSUM_BITS       = 28;
   localparam int LSUM_BITS       = 14;
   localparam int CH_PITCH_BITS   = 14;
   localparam int ADD_BITS        = LEVEL_BITS + CH_PITCH_BITS;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 10;
   localparam int REQ_DATA_BITS   = 40;
   localparam int RSP_DATA_BITS   = 24;

   // shared divider: dividend, divisor and step counter width
   localparam int DIV_BITS        = WSUM_BITS;
   localparam int DIVISOR_BITS    = LSUM_BITS;
   localparam int DIV_CNT_BITS    = $clog2(DIV_BITS);

   localparam int MAX_SENSORS_DEF = 16;

   // arithmetic constants
   localparam int SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;
   localparam int LEVEL_TOP       = 1023;
   localparam int LEVEL_BOTTOM    = 200;   // magnitude of the negative bottom
   localparam int LEVEL_RANGE     = LEVEL_TOP + LEVEL_BOTTOM;
   localparam int PITCH           = 1000;
   localparam int HALF_PITCH      = PITCH / 2;
   localparam int WSUM_MAX        = (1 << WSUM_BITS) - 1;
   localparam int LSUM_MAX        = (1 << LSUM_BITS) - 1;
   localparam int COUNT_MAX       = (1 << COUNT_BITS) - 1;
   localparam int POS_MAX         = (1 << POS_BITS) - 1;

   // configuration reset values
   localparam int NUM_SENSORS_RST = 8;
   localparam int HIGH_THR_RST    = 600;
   localparam int LOW_THR_RST     = 100;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_SENSORS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INVERT      = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HIGH_THR    = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOW_THR     = 2'd3;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_MEASURE   = 2'd0,
      KIND_CAL_SAMPLE = 2'd1,
      KIND_CAL_CLEAR = 2'd2,
      KIND_CAL_LOAD  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DIVIDE,
      ST_LEVEL,
      ST_MULT,
      ST_SUM,
      ST_FINAL,
      ST_STORE
   } state_type;

endpackage

>>> rtl/line_sensor_position_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_sensor_position_top
// calibrated reflectance to weighted centroid line position
// ----------------------------------------------------------------------------
// one item at a time: a beat is taken only in idle; a calibration beat reads and
// writes the memory, a measurement beat also runs the 28-step serial divider
// unless the channel span is zero; the last channel of a frame raises rsp_tvalid
// from the frame end state, or from the store state after a second divider pass
// when the centroid needs one, and waits there while the output register is full
// synchronous active high reset: control registers to defaults, calibration
// reads as min 1023 / max 0 through per-channel valid bits, no clearing pass
// ----------------------------------------------------------------------------
module line_sensor_position_top
   import lsp_pkg::*;
#(
   parameter int MAX_SENSORS = MAX_SENSORS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // request beats
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // channel [3:0], sample_value [13:4], cal_min [23:14], cal_max [33:24]
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,
   // kind [1:0]
   input  logic [KIND_BITS-1:0]      req_tuser,
   // result beats
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // position [13:0], sensors_on_line [18:14], line_lost [19]
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   // configuration writes
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int AW     = $clog2(MAX_SENSORS);
   localparam int NW     = $clog2(MAX_SENSORS + 1);
   localparam int CMP_W  = 8;
   localparam int EDGE_W = 16;

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   state_type                    state_ff, state_in;
   logic [MAX_SENSORS-1:0]       valid_ff, valid_in;

   // configuration
   logic [NUM_BITS-1:0]          num_sensors_ff, num_sensors_in;
   logic                         invert_ff, invert_in;
   logic [LEVEL_BITS-1:0]        high_thr_ff, high_thr_in;
   logic [LEVEL_BITS-1:0]        low_thr_ff, low_thr_in;

   // frame accumulators
   logic [WSUM_BITS-1:0]         wsum_ff, wsum_in;
   logic [LSUM_BITS-1:0]         lsum_ff, lsum_in;
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic [POS_BITS-1:0]          last_pos_ff, last_pos_in;

   // captured beat
   kind_type                     kind_ff, kind_in;
   logic [CHANNEL_BITS-1:0]      ch_ff, ch_in;
   logic [SAMPLE_BITS-1:0]       x_ff, x_in;
   logic [SAMPLE_BITS-1:0]       cmin_ff, cmin_in;
   logic [SAMPLE_BITS-1:0]       cmax_ff, cmax_in;

   // shared serial divider
   logic [DIV_BITS-1:0]          quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0]      rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]      dvs_ff, dvs_in;
   logic [DIV_CNT_BITS-1:0]      div_cnt_ff, div_cnt_in;
   logic                         centroid_ff, centroid_in;
   logic                         neg_ff, neg_in;

   // level and product
   logic [CH_PITCH_BITS-1:0]     ch_pitch_ff, ch_pitch_in;
   logic [LEVEL_BITS-1:0]        level_ff, level_in;
   logic [ADD_BITS-1:0]          add_ff, add_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [POS_BITS-1:0]          rsp_pos_ff, rsp_pos_in;
   logic [COUNT_BITS-1:0]        rsp_cnt_ff, rsp_cnt_in;
   logic                         rsp_lost_ff, rsp_lost_in;

   // ---------------------------------------------------------------------
   // calibration memory: {max, min} per channel
   // ---------------------------------------------------------------------
   logic                         ram_we;
   logic [AW-1:0]                ram_rd_addr;
   logic [AW-1:0]                ram_addr;
   logic [2*SAMPLE_BITS-1:0]     ram_wdata;
   logic [2*SAMPLE_BITS-1:0]     ram_rdata;
   logic [AW+CHANNEL_BITS-1:0]   req_ch_wide;
   logic [AW+CHANNEL_BITS-1:0]   ch_wide;

   logic                         req_beat;

   assign req_beat    = req_tvalid && req_tready;
   assign req_ch_wide = {{AW{1'b0}}, req_tdata[CHANNEL_BITS-1:0]};
   assign ram_rd_addr = req_ch_wide[AW-1:0];
   assign ch_wide     = {{AW{1'b0}}, ch_ff};
   assign ram_addr    = ch_wide[AW-1:0];

   lsp_ram #(
      .WIDTH (2 * SAMPLE_BITS),
      .DEPTH (MAX_SENSORS)
   ) u_cal_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_addr),
      .wr_data (ram_wdata),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rdata)
   );

   // ---------------------------------------------------------------------
   // combinational helpers
   // ---------------------------------------------------------------------
   logic [NW-1:0]                n_eff;
   logic [SAMPLE_BITS-1:0]       cur_min;
   logic [SAMPLE_BITS-1:0]       cur_max;
   logic [SAMPLE_BITS-1:0]       x_meas;
   logic [SAMPLE_BITS:0]         diff_d;
   logic [SAMPLE_BITS:0]         diff_s;
   logic [SAMPLE_BITS-1:0]       mag_d;
   logic [SAMPLE_BITS-1:0]       mag_s;
   logic [DIVISOR_BITS:0]        rem_shift;
   logic                         quo_bit;
   logic                         meas_in_range;
   logic                         cal_in_range;
   logic                         last_channel;
   logic [EDGE_W-1:0]            edge_pos;
   logic [EDGE_W-1:0]            edge_half;
   logic [WSUM_BITS:0]           wsum_sum;
   logic [LSUM_BITS:0]           lsum_sum;
   logic [WSUM_BITS-1:0]         wsum_base;
   logic [LSUM_BITS-1:0]         lsum_base;
   logic [COUNT_BITS-1:0]        count_base;
   logic [POS_BITS-1:0]          quo_sat;

   // channels per frame: zero counts as one, saturated at the memory depth
   always_comb begin
      if (num_sensors_ff == '0) begin
         n_eff = NW'(1);
      end else if (32'(num_sensors_ff) > MAX_SENSORS) begin
         n_eff = NW'(MAX_SENSORS);
      end else begin
         n_eff = NW'(num_sensors_ff);
      end
   end

   assign meas_in_range = CMP_W'(ch_ff) < CMP_W'(n_eff);
   assign cal_in_range  = CMP_W'(ch_ff) < CMP_W'(MAX_SENSORS);
   assign last_channel  = CMP_W'(ch_ff) == (CMP_W'(n_eff) - CMP_W'(1));
   assign edge_pos      = EDGE_W'((n_eff - NW'(1)) * PITCH);
   assign edge_half     = EDGE_W'((n_eff - NW'(1)) * HALF_PITCH);

   // never-written channels read as their reset calibration
   assign cur_min = valid_ff[ram_addr] ? ram_rdata[SAMPLE_BITS-1:0]
                                       : SAMPLE_BITS'(SAMPLE_MAX);
   assign cur_max = valid_ff[ram_addr] ? ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]
                                       : '0;

   // signed offset and span, split into magnitude and sign
   assign x_meas = invert_ff ? (SAMPLE_BITS'(SAMPLE_MAX) - x_ff) : x_ff;
   assign diff_d = {1'b0, x_meas} - {1'b0, cur_min};
   assign diff_s = {1'b0, cur_max} - {1'b0, cur_min};
   assign mag_d  = diff_d[SAMPLE_BITS] ? SAMPLE_BITS'(-diff_d) : diff_d[SAMPLE_BITS-1:0];
   assign mag_s  = diff_s[SAMPLE_BITS] ? SAMPLE_BITS'(-diff_s) : diff_s[SAMPLE_BITS-1:0];

   // one restoring step of the divider
   assign rem_shift = {rem_ff, quo_ff[DIV_BITS-1]};
   assign quo_bit   = rem_shift >= {1'b0, dvs_ff};

   // a frame restarts at channel zero
   assign wsum_base  = (ch_ff == '0) ? '0 : wsum_ff;
   assign lsum_base  = (ch_ff == '0) ? '0 : lsum_ff;
   assign count_base = (ch_ff == '0) ? '0 : count_ff;
   assign wsum_sum   = {1'b0, wsum_base} + (WSUM_BITS + 1)'(add_ff);
   assign lsum_sum   = {1'b0, lsum_base} + (LSUM_BITS + 1)'(level_ff);

   assign quo_sat = (quo_ff[DIV_BITS-1:POS_BITS] != '0) ? POS_BITS'(POS_MAX)
                                                         : quo_ff[POS_BITS-1:0];

   assign req_tready = (state_ff == ST_IDLE);

   // ---------------------------------------------------------------------
   // next state and datapath
   // ---------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      valid_in       = valid_ff;
      num_sensors_in = num_sensors_ff;
      invert_in      = invert_ff;
      high_thr_in    = high_thr_ff;
      low_thr_in     = low_thr_ff;
      wsum_in        = wsum_ff;
      lsum_in        = lsum_ff;
      count_in       = count_ff;
      last_pos_in    = last_pos_ff;
      kind_in        = kind_ff;
      ch_in          = ch_ff;
      x_in           = x_ff;
      cmin_in        = cmin_ff;
      cmax_in        = cmax_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      dvs_in         = dvs_ff;
      div_cnt_in     = div_cnt_ff;
      centroid_in    = centroid_ff;
      neg_in         = neg_ff;
      ch_pitch_in    = ch_pitch_ff;
      level_in       = level_ff;
      add_in         = add_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_cnt_in     = rsp_cnt_ff;
      rsp_lost_in    = rsp_lost_ff;
      ram_we         = 1'b0;
      ram_wdata      = {cur_max, cur_min};

      // configuration writes
      if (csr_we) begin
         case (csr_index)
            CSR_NUM_SENSORS: num_sensors_in = csr_wdata[NUM_BITS-1:0];
            CSR_INVERT:      invert_in      = csr_wdata[0];
            CSR_HIGH_THR:    high_thr_in    = csr_wdata[LEVEL_BITS-1:0];
            CSR_LOW_THR:     low_thr_in     = csr_wdata[LEVEL_BITS-1:0];
            default:         ;
         endcase
      end

      // result beat taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               kind_in  = kind_type'(req_tuser);
               ch_in    = req_tdata[CHANNEL_BITS-1:0];
               x_in     = req_tdata[13:4];
               cmin_in  = req_tdata[23:14];
               cmax_in  = req_tdata[33:24];
               state_in = ST_READ;
            end
         end

         // calibration data is out of the memory now
         ST_READ: begin
            state_in = ST_IDLE;
            if (kind_ff != KIND_MEASURE) begin
               if (cal_in_range) begin
                  ram_we             = 1'b1;
                  valid_in[ram_addr] = 1'b1;
                  case (kind_ff)
                     KIND_CAL_SAMPLE: begin
                        ram_wdata = {(x_ff > cur_max) ? x_ff : cur_max,
                                     (x_ff < cur_min) ? x_ff : cur_min};
                     end
                     KIND_CAL_CLEAR: begin
                        ram_wdata = {SAMPLE_BITS'(0), SAMPLE_BITS'(SAMPLE_MAX)};
                     end
                     KIND_CAL_LOAD: begin
                        ram_wdata = {cmax_ff, cmin_ff};
                     end
                     default: ;
                  endcase
               end
            end else if (meas_in_range) begin
               ch_pitch_in = CH_PITCH_BITS'(ch_ff * PITCH);
               if (diff_s == '0) begin
                  // flat calibration maps to level zero
                  quo_in   = '0;
                  neg_in   = 1'b1;
                  state_in = ST_LEVEL;
               end else begin
                  quo_in      = DIV_BITS'(mag_d) * DIV_BITS'(LEVEL_RANGE);
                  dvs_in      = DIVISOR_BITS'(mag_s);
                  rem_in      = '0;
                  div_cnt_in  = '0;
                  centroid_in = 1'b0;
                  neg_in      = diff_d[SAMPLE_BITS] ^ diff_s[SAMPLE_BITS];
                  state_in    = ST_DIVIDE;
               end
            end
         end

         // one quotient bit per cycle, msb first
         ST_DIVIDE: begin
            quo_in     = {quo_ff[DIV_BITS-2:0], quo_bit};
            rem_in     = quo_bit ? DIVISOR_BITS'(rem_shift - {1'b0, dvs_ff})
                                 : rem_shift[DIVISOR_BITS-1:0];
            div_cnt_in = div_cnt_ff + DIV_CNT_BITS'(1);
            if (div_cnt_ff == DIV_CNT_BITS'(DIV_BITS - 1)) begin
               state_in = centroid_ff ? ST_STORE : ST_LEVEL;
            end
         end

         // quotient minus the bottom offset, clamped to the level range
         ST_LEVEL: begin
            if (neg_ff || (quo_ff < DIV_BITS'(LEVEL_BOTTOM))) begin
               level_in = '0;
            end else if (quo_ff > DIV_BITS'(LEVEL_RANGE)) begin
               level_in = LEVEL_BITS'(LEVEL_TOP);
            end else begin
               level_in = LEVEL_BITS'(quo_ff - DIV_BITS'(LEVEL_BOTTOM));
            end
            state_in = ST_MULT;
         end

         ST_MULT: begin
            add_in   = ADD_BITS'(level_ff) * ADD_BITS'(ch_pitch_ff);
            state_in = ST_SUM;
         end

         // saturating accumulation into the frame sums
         ST_SUM: begin
            wsum_in  = wsum_base;
            lsum_in  = lsum_base;
            count_in = count_base;
            if ((level_ff > high_thr_ff) && (count_base != COUNT_BITS'(COUNT_MAX))) begin
               count_in = count_base + COUNT_BITS'(1);
            end
            if (level_ff > low_thr_ff) begin
               wsum_in = wsum_sum[WSUM_BITS] ? WSUM_BITS'(WSUM_MAX)
                                             : wsum_sum[WSUM_BITS-1:0];
               lsum_in = lsum_sum[LSUM_BITS] ? LSUM_BITS'(LSUM_MAX)
                                             : lsum_sum[LSUM_BITS-1:0];
            end
            state_in = last_channel ? ST_FINAL : ST_IDLE;
         end

         // end of frame: edge report, held position, or centroid divide
         ST_FINAL: begin
            if (count_ff == '0) begin
               if (!rsp_valid_in) begin
                  rsp_valid_in = 1'b1;
                  rsp_pos_in   = (EDGE_W'(last_pos_ff) < edge_half) ? '0
                                                                    : POS_BITS'(edge_pos);
                  rsp_cnt_in   = count_ff;
                  rsp_lost_in  = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (lsum_ff != '0) begin
               quo_in      = wsum_ff;
               dvs_in      = lsum_ff;
               rem_in      = '0;
               div_cnt_in  = '0;
               centroid_in = 1'b1;
               state_in    = ST_DIVIDE;
            end else if (!rsp_valid_in) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = last_pos_ff;
               rsp_cnt_in   = count_ff;
               rsp_lost_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         // centroid done, wait for the output register if still full
         ST_STORE: begin
            if (!rsp_valid_in) begin
               last_pos_in  = quo_sat;
               rsp_valid_in = 1'b1;
               rsp_pos_in   = quo_sat;
               rsp_cnt_in   = count_ff;
               rsp_lost_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         valid_ff       <= '0;
         num_sensors_ff <= NUM_BITS'(NUM_SENSORS_RST);
         invert_ff      <= 1'b0;
         high_thr_ff    <= LEVEL_BITS'(HIGH_THR_RST);
         low_thr_ff     <= LEVEL_BITS'(LOW_THR_RST);
         wsum_ff        <= '0;
         lsum_ff        <= '0;
         count_ff       <= '0;
         last_pos_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         valid_ff       <= valid_in;
         num_sensors_ff <= num_sensors_in;
         invert_ff      <= invert_in;
         high_thr_ff    <= high_thr_in;
         low_thr_ff     <= low_thr_in;
         wsum_ff        <= wsum_in;
         lsum_ff        <= lsum_in;
         count_ff       <= count_in;
         last_pos_ff    <= last_pos_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // payload registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      ch_ff       <= ch_in;
      x_ff        <= x_in;
      cmin_ff     <= cmin_in;
      cmax_ff     <= cmax_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      div_cnt_ff  <= div_cnt_in;
      centroid_ff <= centroid_in;
      neg_ff      <= neg_in;
      ch_pitch_ff <= ch_pitch_in;
      level_ff    <= level_in;
      add_ff      <= add_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_lost_ff <= rsp_lost_in;
   end

   // result beat: position, on-line count, lost flag, zero padding
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_lost_ff, rsp_cnt_ff, rsp_pos_ff};

endmodule

>>> rtl/lsp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module lsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> tb/line_sensor_position_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_sensor_position_checker
// watches the request, result and register ports, predicts every frame
// result from the calibrated weighted centroid and compares it field by field
// ----------------------------------------------------------------------------
module line_sensor_position_checker
   import lsp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   // channel [3:0], sample_value [13:4], cal_min [23:14], cal_max [33:24]
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,
   // kind [1:0]
   input  logic [KIND_BITS-1:0]      req_tuser,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // position [13:0], sensors_on_line [18:14], line_lost [19]
   input  logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                        fail_count,
   output int                        pending
);

   typedef struct {
      logic [POS_BITS-1:0]   position;
      logic [COUNT_BITS-1:0] on_line;
      logic                  lost;
   } frame_result_type;

   frame_result_type expected_frames[$];

   // register copies
   logic [NUM_BITS-1:0]    frame_size;
   logic                   invert_on;
   logic [LEVEL_BITS-1:0]  high_thr;
   logic [LEVEL_BITS-1:0]  low_thr;

   // calibration and frame accumulators
   logic [SAMPLE_BITS-1:0] cal_lo [MAX_SENSORS_DEF];
   logic [SAMPLE_BITS-1:0] cal_hi [MAX_SENSORS_DEF];
   logic [WSUM_BITS-1:0]   weighted_acc;
   logic [LSUM_BITS-1:0]   level_acc;
   logic [COUNT_BITS-1:0]  on_line_acc;
   logic [POS_BITS-1:0]    held_position;
   int                     failures = 0;

   // maps a sample from [lo,hi] to [-200,1023], truncating, then clamps
   function automatic int calibrated_level(int x, int lo, int hi);
      longint span;
      longint v;
      span = hi - lo;
      if (span == 0) return 0;
      v = longint'(x - lo) * LEVEL_RANGE / span - LEVEL_BOTTOM;
      if (v < 0) return 0;
      if (v > LEVEL_TOP) return LEVEL_TOP;
      return int'(v);
   endfunction

   task automatic restore_defaults();
      frame_size    = NUM_BITS'(NUM_SENSORS_RST);
      invert_on     = 1'b0;
      high_thr      = LEVEL_BITS'(HIGH_THR_RST);
      low_thr       = LEVEL_BITS'(LOW_THR_RST);
      for (int i = 0; i < MAX_SENSORS_DEF; i++) begin
         cal_lo[i] = SAMPLE_BITS'(SAMPLE_MAX);
         cal_hi[i] = '0;
      end
      weighted_acc  = '0;
      level_acc     = '0;
      on_line_acc   = '0;
      held_position = '0;
   endtask

   task automatic track_beat(logic [KIND_BITS-1:0] kind_bits, int ch, int sample,
                             int cmin, int cmax);
      kind_type         kind;
      int               n;
      int               x;
      int               level;
      int               add;
      int               edge_pos;
      int               quotient;
      frame_result_type res;
      kind = kind_type'(kind_bits);
      n = (frame_size == 0) ? 1 :
          (frame_size > MAX_SENSORS_DEF) ? MAX_SENSORS_DEF : int'(frame_size);
      case (kind)
         KIND_CAL_SAMPLE: begin
            if (sample > cal_hi[ch]) cal_hi[ch] = SAMPLE_BITS'(sample);
            if (sample < cal_lo[ch]) cal_lo[ch] = SAMPLE_BITS'(sample);
         end
         KIND_CAL_CLEAR: begin
            cal_lo[ch] = SAMPLE_BITS'(SAMPLE_MAX);
            cal_hi[ch] = '0;
         end
         KIND_CAL_LOAD: begin
            cal_lo[ch] = SAMPLE_BITS'(cmin);
            cal_hi[ch] = SAMPLE_BITS'(cmax);
         end
         default: begin
            if (ch < n) begin
               if (ch == 0) begin
                  weighted_acc = '0;
                  level_acc    = '0;
                  on_line_acc  = '0;
               end
               x = invert_on ? SAMPLE_MAX - sample : sample;
               level = calibrated_level(x, int'(cal_lo[ch]), int'(cal_hi[ch]));
               if (level > high_thr && on_line_acc < COUNT_MAX) on_line_acc++;
               if (level > low_thr) begin
                  add = level * ch * PITCH;
                  weighted_acc = WSUM_BITS'((add > WSUM_MAX - int'(weighted_acc)) ?
                                            WSUM_MAX : int'(weighted_acc) + add);
                  level_acc = LSUM_BITS'((level > LSUM_MAX - int'(level_acc)) ?
                                         LSUM_MAX : int'(level_acc) + level);
               end
               if (ch == n - 1) begin
                  res.lost = 1'b0;
                  if (on_line_acc == 0) begin
                     // nothing on the line: report the edge nearest the last position
                     edge_pos = (n - 1) * PITCH;
                     res.position = POS_BITS'((int'(held_position) < edge_pos / 2) ?
                                              0 : edge_pos);
                     res.lost = 1'b1;
                  end else begin
                     if (level_acc != 0) begin
                        quotient = int'(weighted_acc) / int'(level_acc);
                        held_position = POS_BITS'((quotient > POS_MAX) ? POS_MAX : quotient);
                     end
                     res.position = held_position;
                  end
                  res.on_line = on_line_acc;
                  expected_frames.push_back(res);
               end
            end
         end
      endcase
   endtask

   always @(posedge clock) begin : watch
      frame_result_type want;
      frame_result_type seen;
      if (reset) begin
         restore_defaults();
         expected_frames.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_NUM_SENSORS: frame_size = csr_wdata[NUM_BITS-1:0];
               CSR_INVERT:      invert_on  = csr_wdata[0];
               CSR_HIGH_THR:    high_thr   = csr_wdata[LEVEL_BITS-1:0];
               CSR_LOW_THR:     low_thr    = csr_wdata[LEVEL_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.position = rsp_tdata[13:0];
            seen.on_line  = rsp_tdata[18:14];
            seen.lost     = rsp_tdata[19];
            if (expected_frames.size() == 0) begin
               failures++;
               $display("%0t ns: result beat with nothing expected: %s %0d %0d %0d",
                        $time, "position, on_line, lost", seen.position, seen.on_line,
                        seen.lost);
            end else begin
               want = expected_frames.pop_front();
               if (seen.position != want.position) begin
                  failures++;
                  $display("%0t ns: position expected %0d actual %0d",
                           $time, want.position, seen.position);
               end
               if (seen.on_line != want.on_line) begin
                  failures++;
                  $display("%0t ns: sensors_on_line expected %0d actual %0d",
                           $time, want.on_line, seen.on_line);
               end
               if (seen.lost != want.lost) begin
                  failures++;
                  $display("%0t ns: line_lost expected %0d actual %0d",
                           $time, want.lost, seen.lost);
               end
            end
         end
         if (req_tvalid && req_tready)
            track_beat(req_tuser, int'(req_tdata[3:0]), int'(req_tdata[13:4]),
                       int'(req_tdata[23:14]), int'(req_tdata[33:24]));
      end
      pending    <= expected_frames.size();
      fail_count <= failures;
   end

endmodule

>>> tb/tb_line_sensor_position_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_sensor_position_top
// drives calibration and measurement beats into the line sensor position
// block through several register settings and idle patterns; a checker
// beside the block predicts and compares every frame result
// ----------------------------------------------------------------------------
module tb_line_sensor_position_top
   import lsp_pkg::*;
();

   localparam int SETTLE_CYCLES  = 100;    // covers the longest frame end latency
   localparam int WATCHDOG_LIMIT = 4000;   // cycles without any accepted beat
   localparam int PHASE_ITEMS    = 40;     // least random beats per phase beside calibration

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_tvalid  = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata   = '0;
   logic [KIND_BITS-1:0]      req_tuser   = KIND_MEASURE;
   logic                      rsp_tvalid;
   logic                      rsp_tready  = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      csr_we      = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index   = CSR_NUM_SENSORS;
   logic [CSR_DATA_BITS-1:0]  csr_wdata   = '0;

   int fail_count;
   int pending;

   // stimulus state
   int send_idle_pct  = 0;
   int stall_pct      = 0;
   int eff_n          = NUM_SENSORS_RST;
   int invert_now     = 0;
   int counted_items  = 0;
   int idle_cycles    = 0;

   // register settings per random phase, the extremes among them
   int phase_n    [8] = '{8, 16, 1, 0, 31, 5, 16, 12};
   int phase_inv  [8] = '{0, 1, 0, 1, 0, 1, 0, 0};
   int phase_high [8] = '{600, 1023, 0, 300, 500, 700, 400, 600};
   int phase_low  [8] = '{100, 0, 1023, 200, 50, 150, 100, 100};

   line_sensor_position_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   line_sensor_position_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // 2 ns clock
   initial begin
      forever #1 clock = ~clock;
   end

   // result side backpressure, one decision per cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // watchdog: ends the run when no beat moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("tb_line_sensor_position_top failed");
         $finish;
      end
   end

   // one request beat, with random idle cycles ahead of it
   task automatic send_beat(kind_type kind, int ch, int sample, int cmin, int cmax);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'd0, cmax[9:0], cmin[9:0], sample[9:0], ch[3:0]};
      do @(posedge clock); while (!req_tready);
      // measurements past the frame end are ignored by the block
      if (!(kind == KIND_MEASURE && ch >= eff_n)) counted_items++;
   endtask

   // writes all four registers back to back; the block is idle here
   task automatic apply_config(int n, int inv, int hi, int lo);
      csr_we    <= 1'b1;
      csr_index <= CSR_NUM_SENSORS;
      csr_wdata <= CSR_DATA_BITS'(n);
      @(posedge clock);
      csr_index <= CSR_INVERT;
      csr_wdata <= CSR_DATA_BITS'(inv);
      @(posedge clock);
      csr_index <= CSR_HIGH_THR;
      csr_wdata <= CSR_DATA_BITS'(hi);
      @(posedge clock);
      csr_index <= CSR_LOW_THR;
      csr_wdata <= CSR_DATA_BITS'(lo);
      @(posedge clock);
      csr_we    <= 1'b0;
      eff_n      = (n == 0) ? 1 : (n > MAX_SENSORS_DEF) ? MAX_SENSORS_DEF : n;
      invert_now = inv;
   endtask

   // wait for all frame results, then let a measurement still in flight finish
   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // samples lean toward both ends so levels clamp and thresholds flip
   function automatic int pick_sample();
      case ($urandom_range(3))
         0:       return $urandom_range(63);
         1:       return $urandom_range(1023, 960);
         default: return $urandom_range(1023);
      endcase
   endfunction

   task automatic measure_frame();
      for (int c = 0; c < eff_n; c++)
         send_beat(KIND_MEASURE, c, pick_sample(), $urandom_range(1023), $urandom_range(1023));
   endtask

   // usable calibration on every channel, some with zero or inverted span
   task automatic load_calibration();
      int r;
      int lo;
      int hi;
      for (int c = 0; c < MAX_SENSORS_DEF; c++) begin
         r = $urandom_range(9);
         if (r == 0) begin
            lo = $urandom_range(1023);
            hi = lo;
         end else if (r == 1) begin
            lo = $urandom_range(1023, 700);
            hi = $urandom_range(300);
         end else begin
            lo = $urandom_range(300);
            hi = $urandom_range(1023, 700);
         end
         send_beat(KIND_CAL_LOAD, c, $urandom_range(1023), lo, hi);
      end
   endtask

   // mostly whole frames, plus calibration updates, broken frames and noise
   task automatic random_traffic(int budget);
      int start;
      int r;
      int c;
      int len;
      int hot;
      start = counted_items;
      while (counted_items - start < budget) begin
         r = $urandom_range(19);
         if (r <= 10) begin
            measure_frame();
         end else if (r <= 12) begin
            repeat ($urandom_range(4, 1))
               send_beat(KIND_CAL_SAMPLE, $urandom_range(15), $urandom_range(1023),
                         $urandom_range(1023), $urandom_range(1023));
         end else if (r == 13) begin
            // clear a channel and rebuild its range from a couple of samples
            c = $urandom_range(15);
            send_beat(KIND_CAL_CLEAR, c, $urandom_range(1023), $urandom_range(1023),
                      $urandom_range(1023));
            repeat (2)
               send_beat(KIND_CAL_SAMPLE, c, $urandom_range(1023), $urandom_range(1023),
                         $urandom_range(1023));
         end else if (r <= 15) begin
            // channels out of order, missing or repeated
            repeat ($urandom_range(eff_n + 2, 1))
               send_beat(KIND_MEASURE, $urandom_range(eff_n - 1), pick_sample(),
                         $urandom_range(1023), $urandom_range(1023));
         end else if (r <= 17) begin
            // any kind, any channel, any field value
            send_beat(kind_type'($urandom_range(3)), $urandom_range(15), $urandom_range(1023),
                      $urandom_range(1023), $urandom_range(1023));
         end else if (r == 18) begin
            // long run without a frame start drives the sums into saturation
            repeat (20) begin
               hot = invert_now ? $urandom_range(20) : $urandom_range(1023, 1003);
               send_beat(KIND_MEASURE, $urandom_range(eff_n - 1, (eff_n > 2) ? 1 : 0), hot,
                         $urandom_range(1023), $urandom_range(1023));
            end
            send_beat(KIND_MEASURE, eff_n - 1, pick_sample(), 0, 0);
         end else begin
            // frame abandoned midway and restarted
            len = $urandom_range(eff_n - 1);
            for (c = 0; c < len; c++)
               send_beat(KIND_MEASURE, c, pick_sample(), $urandom_range(1023),
                         $urandom_range(1023));
            measure_frame();
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, four channels, no idling
      apply_config(4, 0, 600, 100);
      send_beat(KIND_CAL_CLEAR,  0, 0, 0, 0);
      send_beat(KIND_CAL_SAMPLE, 1, 0, 0, 0);
      send_beat(KIND_CAL_SAMPLE, 1, 1023, 0, 0);
      send_beat(KIND_CAL_LOAD,   2, 0, 500, 500);       // zero span maps to level 0
      send_beat(KIND_CAL_LOAD,   3, 0, 900, 100);       // min above max
      send_beat(KIND_CAL_LOAD,   0, 0, 0, 1023);
      send_beat(KIND_CAL_LOAD,  15, 1023, 1023, 0);     // top channel, full ranges
      // sensors on line at both ends of the frame
      send_beat(KIND_MEASURE, 0, 1023, 0, 0);
      send_beat(KIND_MEASURE, 1, 1023, 0, 0);
      send_beat(KIND_MEASURE, 2, 700, 0, 0);
      send_beat(KIND_MEASURE, 3, 0, 0, 0);
      // nothing on line: edge reported from the last position
      send_beat(KIND_MEASURE, 0, 0, 0, 0);
      send_beat(KIND_MEASURE, 1, 0, 0, 0);
      send_beat(KIND_MEASURE, 2, 1023, 0, 0);
      send_beat(KIND_MEASURE, 3, 900, 0, 0);
      // channel past the frame is dropped; last channel alone keeps accumulating
      send_beat(KIND_MEASURE, 9, 1023, 1023, 1023);
      send_beat(KIND_MEASURE, 3, 0, 0, 0);
      drain_and_settle();

      // inverted samples, on line but no level above the low threshold: position held
      apply_config(4, 1, 0, 1023);
      for (int c = 0; c < 4; c++) send_beat(KIND_MEASURE, c, 0, 0, 0);
      drain_and_settle();

      // random phases, each with its own settings and idle pattern
      for (int p = 0; p < 8; p++) begin
         apply_config(phase_n[p], phase_inv[p], phase_high[p], phase_low[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 61; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 61; end
            default: begin send_idle_pct = 12; stall_pct = 12; end
         endcase
         load_calibration();
         random_traffic(PHASE_ITEMS);
         drain_and_settle();
      end

      if (fail_count == 0) begin
         $display("tb_line_sensor_position_top passed");
      end else begin
         $display("tb_line_sensor_position_top failed");
      end
      $finish;
   end

endmodule
